// File: rtl/pli_pkg.sv
// Package for the piecewise linear interpolator: widths, codes, the search
// token that travels along the cell row and the table write bus.
// No dependencies.
package pli_pkg;

  localparam int DATA_W          = 32;
  localparam int CFG_W           = 6;
  localparam int ENTRY_INDEX_W   = 5;
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int QUOT_W          = 34;
  localparam int DIV_STEPS       = 64;

  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(2);
  localparam logic [QUOT_W-1:0] QUOT_CAP  = {1'b1, {(QUOT_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] Y_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Y_MIN     = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_INSIDE = 2'd0,
    ST_BELOW  = 2'd1,
    ST_BEYOND = 2'd2,
    ST_FLAT   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DIFF,
    S_MUL,
    S_DLOAD,
    S_DIV,
    S_FINISH
  } state_t;

  // Search token: query value, the pair seen one cell back and the chosen segment
  typedef struct packed {
    logic              vld;
    logic              done;
    logic              need_hi;
    status_t           status;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] prev_x;
    logic [DATA_W-1:0] prev_y;
    logic [DATA_W-1:0] lo_x;
    logic [DATA_W-1:0] lo_y;
    logic [DATA_W-1:0] hi_x;
    logic [DATA_W-1:0] hi_y;
  } tok_t;

  typedef struct packed {
    logic                     valid;
    logic [ENTRY_INDEX_W-1:0] index;
    logic [DATA_W-1:0]        x;
    logic [DATA_W-1:0]        y;
  } wr_t;

endpackage

// File: rtl/pli_cell.sv
// One cell of the breakpoint row: holds one (x, y) pair and one stage of the
// search token, which it hands to the next cell every cycle.
// Depends on pli_pkg.
module pli_cell #(
  parameter int IDX = 0,
  parameter int NW  = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pli_pkg::wr_t   wr,
  input  logic [NW-1:0]  n_eff,
  input  logic [NW-1:0]  n_last,
  input  pli_pkg::tok_t  tok_in,
  output pli_pkg::tok_t  tok_out
);
  import pli_pkg::*;

  localparam logic [NW-1:0] K = NW'(IDX);
  localparam bit WRITABLE = (IDX < (1 << ENTRY_INDEX_W));

  logic [DATA_W-1:0] x_r;
  logic [DATA_W-1:0] y_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              wr_hit;

  assign wr_hit = WRITABLE && wr.valid && (32'(wr.index) == 32'(IDX));

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      x_r <= wr.x;
      y_r <= wr.y;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld) begin
      if (tok_in.need_hi) begin
        // segment below the first breakpoint: take the second entry as its end
        tok_nxt.hi_x    = x_r;
        tok_nxt.hi_y    = y_r;
        tok_nxt.need_hi = 1'b0;
        tok_nxt.done    = 1'b1;
      end else if (!tok_in.done && (K < n_eff)) begin
        if ($signed(x_r) > $signed(tok_in.q)) begin
          if (IDX == 0) begin
            tok_nxt.lo_x    = x_r;
            tok_nxt.lo_y    = y_r;
            tok_nxt.need_hi = 1'b1;
            tok_nxt.status  = ST_BELOW;
          end else begin
            tok_nxt.lo_x   = tok_in.prev_x;
            tok_nxt.lo_y   = tok_in.prev_y;
            tok_nxt.hi_x   = x_r;
            tok_nxt.hi_y   = y_r;
            tok_nxt.status = ST_INSIDE;
            tok_nxt.done   = 1'b1;
          end
        end else if (K == n_last) begin
          tok_nxt.lo_x   = tok_in.prev_x;
          tok_nxt.lo_y   = tok_in.prev_y;
          tok_nxt.hi_x   = x_r;
          tok_nxt.hi_y   = y_r;
          tok_nxt.status = ST_BEYOND;
          tok_nxt.done   = 1'b1;
        end
      end
      tok_nxt.prev_x = x_r;
      tok_nxt.prev_y = y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: rtl/pli_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit
// nonzero divisor, quotient capped at 2^33. Depends on pli_pkg.
module pli_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [2*pli_pkg::DATA_W-1:0] dividend,
  input  logic [pli_pkg::DATA_W-1:0]   divisor,
  output logic                         done,
  output logic [pli_pkg::QUOT_W-1:0]   quotient
);
  import pli_pkg::*;

  localparam int DW = 2 * DATA_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DW-1:0]     dvd_r;
  logic [DW-1:0]     quo_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dvs_r;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic              ge;
  logic              over;

  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  // anything past 2^33 saturates the final sum anyway
  assign over = (|quo_r[DW-1:QUOT_W]) | (quo_r[QUOT_W-1] & (|quo_r[QUOT_W-2:0]));
  assign quotient = over ? QUOT_CAP : quo_r[QUOT_W-1:0];
  assign done = done_r;

endmodule

// File: rtl/piecewise_linear_interpolator_core.sv
// Piecewise linear interpolator core: a row of breakpoint cells, a 32x32
// multiplier stage and a bit-serial divider. Depends on pli_pkg, pli_cell, pli_div.
//
// Usage:
//   Items enter on in_* with start; an item is taken at an edge where start
//   is high and busy is low. in_func selects a table write (entry_index,
//   knot_x, knot_y) or a query (query_x). A write lands in its cell at the
//   accepting edge, produces no result and leaves busy low.
//   A query raises busy. The search token walks the cell row one cell per
//   cycle, so the row length TABLE_DEPTH sets the search time; the segment
//   is then differenced, multiplied and divided one quotient bit per cycle;
//   a zero-width segment skips the divide. The result shows on out_interp_y /
//   out_status with out_valid high for one cycle; busy falls in that cycle.
//   out_valid is a strobe: the receiver cannot stall the result.
//   cfg_entries_in_use is written on cfg_valid & cfg_ready (ready is always
//   high); write it only while busy is low.
//   Reset sets entries_in_use to 2 and clears the control state; table
//   contents are undefined until written and get no clearing pass.
module piecewise_linear_interpolator_core #(
  parameter int TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_func,
  input  logic [pli_pkg::ENTRY_INDEX_W-1:0] in_entry_index,
  input  logic signed [pli_pkg::DATA_W-1:0] in_knot_x,
  input  logic signed [pli_pkg::DATA_W-1:0] in_knot_y,
  input  logic signed [pli_pkg::DATA_W-1:0] in_query_x,
  output logic                              out_valid,
  output logic signed [pli_pkg::DATA_W-1:0] out_interp_y,
  output logic [1:0]                        out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pli_pkg::CFG_W-1:0]         cfg_entries_in_use
);
  import pli_pkg::*;

  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (NW > CFG_W) ? NW : CFG_W;

  state_t state_r;
  state_t state_nxt;

  logic [CFG_W-1:0] entries_r;
  logic [CW-1:0]    cfg_ext;
  logic [CW-1:0]    n_clamp;
  logic [NW-1:0]    n_eff;
  logic [NW-1:0]    n_last;

  logic   accept;
  wr_t    wr;
  tok_t   inject;
  tok_t   tok [TABLE_DEPTH+1];
  tok_t   tok_end;

  logic              capture_en;
  logic              diff_en;
  logic              mul_en;
  logic              div_start;
  logic              out_load;
  logic              div_done;
  logic [QUOT_W-1:0] quot;

  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] x0_r;
  logic [DATA_W-1:0] x1_r;
  logic [DATA_W-1:0] y0_r;
  logic [DATA_W-1:0] y1_r;
  status_t           seg_status_r;

  logic [DATA_W:0]   dx;
  logic [DATA_W:0]   dy;
  logic [DATA_W:0]   dq;
  logic [DATA_W:0]   dx_abs;
  logic [DATA_W:0]   dy_abs;
  logic [DATA_W:0]   dq_abs;
  logic [DATA_W-1:0] mdx_r;
  logic [DATA_W-1:0] mdy_r;
  logic [DATA_W-1:0] mdq_r;
  logic              sdx_r;
  logic              sdy_r;
  logic              sdq_r;
  logic              dx_zero_r;
  logic [2*DATA_W-1:0] prod_r;

  logic              neg;
  logic [DATA_W+2:0] y0_ext;
  logic [DATA_W+2:0] quot_ext;
  logic [DATA_W+2:0] sum;
  logic [DATA_W-1:0] y_final;
  status_t           status_final;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_y_r;
  status_t           out_status_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entries_r <= cfg_entries_in_use;
    end
  end
  assign cfg_ready = 1'b1;

  // clamp the searched count to [2, TABLE_DEPTH]
  always_comb begin
    cfg_ext = CW'(entries_r);
    if (cfg_ext < CW'(2)) begin
      n_clamp = CW'(2);
    end else if (cfg_ext > CW'(TABLE_DEPTH)) begin
      n_clamp = CW'(TABLE_DEPTH);
    end else begin
      n_clamp = cfg_ext;
    end
  end
  assign n_eff  = NW'(n_clamp);
  assign n_last = n_eff - NW'(1);

  assign accept   = start && !busy;
  assign wr.valid = accept && (in_func == FUNC_WRITE);
  assign wr.index = in_entry_index;
  assign wr.x     = in_knot_x;
  assign wr.y     = in_knot_y;

  always_comb begin
    inject     = '0;
    inject.vld = accept && (in_func == FUNC_QUERY);
    inject.q   = in_query_x;
  end

  assign tok[0] = inject;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    pli_cell #(
      .IDX (k),
      .NW  (NW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .n_eff   (n_eff),
      .n_last  (n_last),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  assign tok_end = tok[TABLE_DEPTH];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    busy       = 1'b1;
    capture_en = 1'b0;
    diff_en    = 1'b0;
    mul_en     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start && (in_func == FUNC_QUERY)) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (tok_end.vld) begin
          capture_en = 1'b1;
          state_nxt  = S_DIFF;
        end
      end
      S_DIFF: begin
        diff_en   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        mul_en    = 1'b1;
        state_nxt = dx_zero_r ? S_FINISH : S_DLOAD;
      end
      S_DLOAD: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        out_load  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // segment capture and differences
  assign dx = {x1_r[DATA_W-1], x1_r} - {x0_r[DATA_W-1], x0_r};
  assign dy = {y1_r[DATA_W-1], y1_r} - {y0_r[DATA_W-1], y0_r};
  assign dq = {q_r[DATA_W-1], q_r} - {x0_r[DATA_W-1], x0_r};
  assign dx_abs = dx[DATA_W] ? -dx : dx;
  assign dy_abs = dy[DATA_W] ? -dy : dy;
  assign dq_abs = dq[DATA_W] ? -dq : dq;

  always_ff @(posedge clk) begin
    if (capture_en) begin
      q_r          <= tok_end.q;
      x0_r         <= tok_end.lo_x;
      y0_r         <= tok_end.lo_y;
      x1_r         <= tok_end.hi_x;
      y1_r         <= tok_end.hi_y;
      seg_status_r <= tok_end.status;
    end
    if (diff_en) begin
      mdx_r     <= dx_abs[DATA_W-1:0];
      mdy_r     <= dy_abs[DATA_W-1:0];
      mdq_r     <= dq_abs[DATA_W-1:0];
      sdx_r     <= dx[DATA_W];
      sdy_r     <= dy[DATA_W];
      sdq_r     <= dq[DATA_W];
      dx_zero_r <= (dx == '0);
    end
    if (mul_en) begin
      prod_r <= mdy_r * mdq_r;
    end
  end

  pli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (mdx_r),
    .done     (div_done),
    .quotient (quot)
  );

  // final sum and saturation
  assign neg      = sdy_r ^ sdq_r ^ sdx_r;
  assign y0_ext   = {{3{y0_r[DATA_W-1]}}, y0_r};
  assign quot_ext = (DATA_W + 3)'(quot);
  assign sum      = neg ? (y0_ext - quot_ext) : (y0_ext + quot_ext);

  always_comb begin
    status_final = seg_status_r;
    if (dx_zero_r) begin
      status_final = ST_FLAT;
      if (prod_r == '0) begin
        y_final = y0_r;
      end else begin
        y_final = (sdy_r ^ sdq_r) ? Y_MIN : Y_MAX;
      end
    end else if (sum[DATA_W+2:DATA_W-1] != {4{sum[DATA_W+2]}}) begin
      y_final = sum[DATA_W+2] ? Y_MIN : Y_MAX;
    end else begin
      y_final = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_y_r      <= y_final;
      out_status_r <= status_final;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_interp_y = out_y_r;
  assign out_status   = out_status_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_QUERY)) |=> busy)
    else $error("query transfer did not raise busy");

  a_token_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !tok_end.vld)
    else $error("search token left the cell row while idle");

  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

endmodule
